/* rtl/core/sus_pkg.sv */
// shared types and constants for the sorted unique set
package sus_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 6;
  localparam int CAPACITY_DF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic                     cmp;
    cell_mode_t               mode;
    logic signed [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

/* rtl/core/sus_if.sv */
// handshake channels for request and response beats
interface sus_in_if;
  logic                              valid;
  logic                              ready;
  logic [sus_pkg::OP_W-1:0]          op;
  logic signed [sus_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sus_out_if;
  logic                              valid;
  logic                              ready;
  logic [sus_pkg::STATUS_W-1:0]      status;
  logic signed [sus_pkg::DATA_W-1:0] item_value;
  logic [sus_pkg::COUNT_W-1:0]       entry_count;
  logic                              last;

  modport source (output valid, output status, output item_value, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input status, input item_value, input entry_count,
                  input last, output ready);
endinterface

/* rtl/core/sus_cell.sv */
// one storage cell of the sorted chain
module sus_cell #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DF,
  parameter int INDEX    = 0,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  sus_pkg::cell_ctl_t                ctl,
  input  logic [CNT_W-1:0]                  count,
  input  logic [CNT_W-1:0]                  last_idx,
  input  logic signed [sus_pkg::DATA_W-1:0] prev_value,
  input  logic                              prev_lt,
  input  logic signed [sus_pkg::DATA_W-1:0] next_value,
  input  logic signed [sus_pkg::DATA_W-1:0] head_value,
  output logic signed [sus_pkg::DATA_W-1:0] value,
  output logic                              lt,
  output logic                              eq
);

  logic                              occupied;
  logic signed [sus_pkg::DATA_W-1:0] value_next;

  assign occupied = CNT_W'(INDEX) < count;

  always_comb begin
    value_next = value;
    case (ctl.mode)
      sus_pkg::CELL_INSERT: begin
        if (!lt) begin
          value_next = (INDEX == 0 || prev_lt) ? ctl.key : prev_value;
        end
      end
      sus_pkg::CELL_DELETE: begin
        if (!lt) begin
          value_next = next_value;
        end
      end
      sus_pkg::CELL_ROTATE: begin
        value_next = (CNT_W'(INDEX) == last_idx) ? head_value : next_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (ctl.cmp) begin
      lt <= occupied && (value < ctl.key);
      eq <= occupied && (value == ctl.key);
    end
  end

endmodule

/* rtl/core/sorted_unique_set_insert_delete.sv */
// sorted unique set: insert, delete, dump (one beat per entry, one empty beat if none); rsp stalls hold it
// one beat accepted per item; the next item is taken the cycle after the result is registered
// the chain of cells compares the key in the accept cycle and shifts once the response slot is free
// dump rotates the occupied cells one step per cycle while the response slot is free and streams the head cell
// rst is synchronous: clears the entry count and control; cell contents are left as they are
module sorted_unique_set_insert_delete #(
  parameter int CAPACITY = sus_pkg::CAPACITY_DF
) (
  input  logic      clk,
  input  logic      rst,
  sus_in_if.sink    req,
  sus_out_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESOLVE,
    S_DUMP
  } state_t;

  state_t                            state;
  sus_pkg::op_t                      op_q;
  logic signed [sus_pkg::DATA_W-1:0] key_q;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  dump_k;
  logic [CNT_W-1:0]                  last_idx;

  logic                              out_valid;
  sus_pkg::status_t                  out_status;
  logic signed [sus_pkg::DATA_W-1:0] out_value;
  logic [CNT_W-1:0]                  out_count;
  logic                              out_last;

  sus_pkg::cell_ctl_t                ctl;
  logic signed [sus_pkg::DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]               cell_lt;
  logic [CAPACITY-1:0]               cell_eq;

  logic accept;
  logic slot_free;
  logic found;
  logic full;
  logic load;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign slot_free   = !out_valid || rsp.ready;
  assign found       = |cell_eq;
  assign full        = (count == CNT_W'(CAPACITY));
  assign last_idx    = count - CNT_W'(1);

  // a result beat is registered this cycle
  assign load = slot_free &&
                ((state == S_RESOLVE &&
                  (op_q == sus_pkg::OP_INSERT || op_q == sus_pkg::OP_DELETE ||
                   (op_q == sus_pkg::OP_DUMP && count == '0))) ||
                 state == S_DUMP);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.item_value  = out_value;
  assign rsp.entry_count = sus_pkg::COUNT_W'(out_count);
  assign rsp.last        = out_last;

  // cell control: compare on accept, shift when the result is registered
  always_comb begin
    ctl.cmp  = accept;
    ctl.key  = (state == S_IDLE) ? req.value : key_q;
    ctl.mode = sus_pkg::CELL_HOLD;
    if (state == S_RESOLVE && slot_free) begin
      if (op_q == sus_pkg::OP_INSERT && !found && !full) begin
        ctl.mode = sus_pkg::CELL_INSERT;
      end else if (op_q == sus_pkg::OP_DELETE && found) begin
        ctl.mode = sus_pkg::CELL_DELETE;
      end
    end else if (state == S_DUMP && slot_free) begin
      ctl.mode = sus_pkg::CELL_ROTATE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [sus_pkg::DATA_W-1:0] prev_v;
    logic signed [sus_pkg::DATA_W-1:0] next_v;
    logic                              prev_l;

    if (i == 0) begin : g_first
      assign prev_v = ctl.key;
      assign prev_l = 1'b0;
    end else begin : g_mid
      assign prev_v = cell_value[i-1];
      assign prev_l = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = cell_value[i];
    end else begin : g_body
      assign next_v = cell_value[i+1];
    end

    sus_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .last_idx   (last_idx),
      .prev_value (prev_v),
      .prev_lt    (prev_l),
      .next_value (next_v),
      .head_value (cell_value[0]),
      .value      (cell_value[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_k    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= sus_pkg::op_t'(req.op);
            key_q <= req.value;
            if (sus_pkg::op_t'(req.op) != sus_pkg::OP_NONE) begin
              state <= S_RESOLVE;
            end
          end
        end
        S_RESOLVE: begin
          if (slot_free) begin
            out_last <= 1'b1;
            case (op_q)
              sus_pkg::OP_INSERT: begin
                out_value <= key_q;
                state     <= S_IDLE;
                if (found) begin
                  out_status <= sus_pkg::ST_DUP;
                  out_count  <= count;
                end else if (full) begin
                  out_status <= sus_pkg::ST_FULL;
                  out_count  <= count;
                end else begin
                  out_status <= sus_pkg::ST_INSERTED;
                  out_count  <= count + CNT_W'(1);
                  count      <= count + CNT_W'(1);
                end
              end
              sus_pkg::OP_DELETE: begin
                out_value <= key_q;
                state     <= S_IDLE;
                if (found) begin
                  out_status <= sus_pkg::ST_DELETED;
                  out_count  <= last_idx;
                  count      <= last_idx;
                end else begin
                  out_status <= sus_pkg::ST_NOTFOUND;
                  out_count  <= count;
                end
              end
              sus_pkg::OP_DUMP: begin
                if (count == '0) begin
                  out_status <= sus_pkg::ST_EMPTY;
                  out_value  <= '0;
                  out_count  <= count;
                  state      <= S_IDLE;
                end else begin
                  // no beat yet: start streaming next cycle
                  dump_k <= '0;
                  state  <= S_DUMP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            out_status <= sus_pkg::ST_ENTRY;
            out_value  <= cell_value[0];
            out_count  <= count;
            out_last   <= (dump_k == last_idx);
            dump_k     <= dump_k + CNT_W'(1);
            if (dump_k == last_idx) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
